FILE: rtl/bsfb_pkg.sv
package bsfb_pkg;

  // Store geometry and reserved room around the payload.
  localparam int STORE_BYTES  = 1024;
  localparam int HEADER_ROOM  = 5;
  localparam int TRAILER_ROOM = 4;
  localparam int PAYLOAD_ROOM = STORE_BYTES - HEADER_ROOM - TRAILER_ROOM;
  localparam int ADDR_W       = $clog2(STORE_BYTES);

  // Fixed field widths.
  localparam int IDX_W  = 10;
  localparam int LEN_W  = 11;
  localparam int SUM_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Register reset values.
  localparam logic [7:0] HEAD_RESET = 8'hAA;
  localparam logic [7:0] ESC_RESET  = 8'h55;
  localparam logic [7:0] MASK_RESET = 8'h20;

  // Close sequence slots: head, length low/high, checksum low/high.
  localparam int SLOT_W = 4;
  localparam logic [SLOT_W-1:0] SLOT_HEAD     = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_LO_A     = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_LO_B     = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_HI_A     = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_HI_B     = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_C0_A     = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_C0_B     = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_C1_A     = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_C1_B     = 4'd8;

  typedef enum logic [1:0] {
    OP_PAYLOAD = 2'd0,
    OP_CLOSE   = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD = 2'd0,
    REG_ESC  = 2'd1,
    REG_MASK = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PAY2,
    BK_CLOSE,
    BK_READ
  } back_state_e;

  typedef struct packed {
    logic [7:0] head;
    logic [7:0] esc;
    logic [7:0] mask;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
  } item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] len;
    logic             ovr;
    logic             rdy;
  } res_t;

  // A byte that must be escaped inside the frame.
  function automatic logic is_special(input logic [7:0] b, input cfg_t cfg);
    is_special = (b == cfg.head) || (b == cfg.esc);
  endfunction

endpackage

FILE: rtl/bsfb_ram.sv
module bsfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port: a write or a registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bsfb_front.sv
module bsfb_front import bsfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  logic [7:0]       data_byte_i,
  input  logic [IDX_W-1:0] read_index_i,
  output item_t            item_o,
  output logic             item_valid_o,
  input  logic             item_pop_i
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  item_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push, pop;
  item_t             item_in;

  // Classify the incoming word: the op code becomes its enum.
  always_comb begin
    item_in.op   = op_e'(op_i);
    item_in.data = data_byte_i;
    item_in.idx  = read_index_i;
  end

  assign in_ready_o   = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  // Queue pointers and fill count.
  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage holds every accepted word: op, data byte and read index.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item_in;
    end
  end

endmodule

FILE: rtl/bsfb_back.sv
module bsfb_back import bsfb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  item_t item_i,
  input  logic  item_valid_i,
  output logic  item_pop_o,
  input  logic  res_ok_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] spc_q, spc_d;
  logic [ADDR_W-1:0] raw_q, raw_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [2:0]        hsc_q, hsc_d;
  logic [2:0]        tsc_q, tsc_d;
  logic              closed_q, closed_d;
  logic [7:0]        pay_q, pay_d;
  logic [7:0]        lo_q, lo_d;
  logic [7:0]        hi_q, hi_d;
  logic [SUM_W-1:0]  chk_q, chk_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [ADDR_W-1:0] waddr_q, waddr_d;

  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic              special_data, ovf, rd_hit;
  logic [ADDR_W-1:0] pay_addr, rd_addr, start_addr;
  logic [SUM_W-1:0]  raw16, sum1, chk_new;
  logic [7:0]        cl_lo, cl_hi;
  logic [2:0]        hsc_new, hsc_fin, tsc_fin;
  logic [LEN_W-1:0]  total;
  logic              e_lo, e_hi, e_c0, e_c1;
  logic              slot_en;
  logic [7:0]        slot_data;
  logic [7:0]        res_byte;
  logic              res_ovr;

  // Decode of the queued word against the current frame state.
  assign special_data = is_special(item_i.data, cfg_i);
  assign ovf = (ADDR_W + 1)'(spc_q) + (ADDR_W + 1)'(2) > (ADDR_W + 1)'(PAYLOAD_ROOM);
  assign pay_addr = ADDR_W'(HEADER_ROOM) + spc_q;
  assign total = LEN_W'(1) + LEN_W'(hsc_q) + LEN_W'(spc_q) + LEN_W'(tsc_q);
  assign rd_hit = closed_q && (LEN_W'(item_i.idx) < total);
  assign rd_addr = ADDR_W'(HEADER_ROOM - 1) - ADDR_W'(hsc_q) + ADDR_W'(item_i.idx);

  // Close preparation: length bytes, checksum and header start.
  assign raw16   = SUM_W'(raw_q);
  assign cl_lo   = raw16[7:0];
  assign cl_hi   = raw16[15:8];
  assign sum1    = sum_q + SUM_W'(cl_lo) + SUM_W'(cl_hi);
  assign chk_new = SUM_W'(0) - sum1;
  assign hsc_new = 3'd2 + 3'(is_special(cl_lo, cfg_i)) + 3'(is_special(cl_hi, cfg_i));
  assign start_addr = ADDR_W'(HEADER_ROOM - 1) - ADDR_W'(hsc_new);

  // Escape flags of the captured close bytes.
  assign e_lo    = is_special(lo_q, cfg_i);
  assign e_hi    = is_special(hi_q, cfg_i);
  assign e_c0    = is_special(chk_q[7:0], cfg_i);
  assign e_c1    = is_special(chk_q[15:8], cfg_i);
  assign hsc_fin = 3'd2 + 3'(e_lo) + 3'(e_hi);
  assign tsc_fin = 3'd2 + 3'(e_c0) + 3'(e_c1);

  // Byte written in each slot of the close sequence.
  always_comb begin
    slot_en   = 1'b0;
    slot_data = '0;
    case (slot_q)
      SLOT_HEAD: begin slot_en = 1'b1; slot_data = cfg_i.head; end
      SLOT_LO_A: begin slot_en = 1'b1; slot_data = e_lo ? cfg_i.esc : lo_q; end
      SLOT_LO_B: begin slot_en = e_lo; slot_data = lo_q ^ cfg_i.mask; end
      SLOT_HI_A: begin slot_en = 1'b1; slot_data = e_hi ? cfg_i.esc : hi_q; end
      SLOT_HI_B: begin slot_en = e_hi; slot_data = hi_q ^ cfg_i.mask; end
      SLOT_C0_A: begin slot_en = 1'b1; slot_data = e_c0 ? cfg_i.esc : chk_q[7:0]; end
      SLOT_C0_B: begin slot_en = e_c0; slot_data = chk_q[7:0] ^ cfg_i.mask; end
      SLOT_C1_A: begin slot_en = 1'b1; slot_data = e_c1 ? cfg_i.esc : chk_q[15:8]; end
      SLOT_C1_B: begin slot_en = e_c1; slot_data = chk_q[15:8] ^ cfg_i.mask; end
      default: begin slot_en = 1'b0; slot_data = '0; end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          case (item_i.op)
            OP_PAYLOAD: if (!closed_q && !ovf && special_data) state_d = BK_PAY2;
            OP_CLOSE:   if (!closed_q && (raw_q != '0)) state_d = BK_CLOSE;
            OP_READ:    if (rd_hit) state_d = BK_READ;
            default:    state_d = BK_IDLE;
          endcase
        end
      end
      BK_PAY2:  if (res_ok_i) state_d = BK_IDLE;
      BK_CLOSE: if ((slot_q == SLOT_C1_B) && res_ok_i) state_d = BK_IDLE;
      BK_READ:  if (res_ok_i) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Datapath, memory access and result for each state.
  always_comb begin
    spc_d       = spc_q;
    raw_d       = raw_q;
    sum_d       = sum_q;
    hsc_d       = hsc_q;
    tsc_d       = tsc_q;
    closed_d    = closed_q;
    pay_d       = pay_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    chk_d       = chk_q;
    slot_d      = slot_q;
    waddr_d     = waddr_q;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = waddr_q;
    ram_wdata   = '0;
    item_pop_o  = 1'b0;
    res_valid_o = 1'b0;
    res_byte    = '0;
    res_ovr     = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          case (item_i.op)
            OP_PAYLOAD: begin
              if (closed_q) begin
                // Bytes after close are dropped until the next clear.
                if (res_ok_i) begin
                  item_pop_o  = 1'b1;
                  res_valid_o = 1'b1;
                end
              end else if (ovf) begin
                if (res_ok_i) begin
                  item_pop_o  = 1'b1;
                  res_valid_o = 1'b1;
                  res_ovr     = 1'b1;
                  spc_d       = '0;
                  raw_d       = '0;
                  sum_d       = '0;
                  hsc_d       = '0;
                  tsc_d       = '0;
                  closed_d    = 1'b0;
                end
              end else if (special_data) begin
                // First half of an escaped byte: the escape marker.
                item_pop_o = 1'b1;
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_addr   = pay_addr;
                ram_wdata  = cfg_i.esc;
                pay_d      = item_i.data;
              end else if (res_ok_i) begin
                item_pop_o  = 1'b1;
                res_valid_o = 1'b1;
                ram_en      = 1'b1;
                ram_we      = 1'b1;
                ram_addr    = pay_addr;
                ram_wdata   = item_i.data;
                sum_d       = sum_q + SUM_W'(item_i.data);
                spc_d       = spc_q + 1'b1;
                raw_d       = raw_q + 1'b1;
              end
            end
            OP_CLOSE: begin
              if (closed_q || (raw_q == '0)) begin
                if (res_ok_i) begin
                  item_pop_o  = 1'b1;
                  res_valid_o = 1'b1;
                end
              end else begin
                item_pop_o = 1'b1;
                lo_d       = cl_lo;
                hi_d       = cl_hi;
                chk_d      = chk_new;
                slot_d     = SLOT_HEAD;
                waddr_d    = start_addr;
              end
            end
            OP_READ: begin
              if (rd_hit) begin
                item_pop_o = 1'b1;
                ram_en     = 1'b1;
                ram_addr   = rd_addr;
              end else if (res_ok_i) begin
                item_pop_o  = 1'b1;
                res_valid_o = 1'b1;
              end
            end
            default: begin
              if (res_ok_i) begin
                item_pop_o  = 1'b1;
                res_valid_o = 1'b1;
                spc_d       = '0;
                raw_d       = '0;
                sum_d       = '0;
                hsc_d       = '0;
                tsc_d       = '0;
                closed_d    = 1'b0;
              end
            end
          endcase
        end
      end
      BK_PAY2: begin
        // Second half of an escaped byte: the masked value.
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = pay_addr + 1'b1;
        ram_wdata = pay_q ^ cfg_i.mask;
        if (res_ok_i) begin
          res_valid_o = 1'b1;
          sum_d       = sum_q + SUM_W'(pay_q);
          spc_d       = spc_q + ADDR_W'(2);
          raw_d       = raw_q + 1'b1;
        end
      end
      BK_CLOSE: begin
        ram_en    = slot_en;
        ram_we    = slot_en;
        ram_addr  = waddr_q;
        ram_wdata = slot_data;
        if (slot_q == SLOT_HI_B) begin
          // Header done; the trailer follows the stuffed payload.
          slot_d  = slot_q + 1'b1;
          waddr_d = pay_addr;
        end else if (slot_q != SLOT_C1_B) begin
          slot_d  = slot_q + 1'b1;
          waddr_d = slot_en ? waddr_q + 1'b1 : waddr_q;
        end else if (res_ok_i) begin
          res_valid_o = 1'b1;
          closed_d    = 1'b1;
          hsc_d       = hsc_fin;
          tsc_d       = tsc_fin;
          sum_d       = chk_q;
        end
      end
      BK_READ: begin
        if (res_ok_i) begin
          res_valid_o = 1'b1;
          res_byte    = ram_rdata;
        end
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  // Result word reflects the state after the operation.
  always_comb begin
    res_o.out_byte = res_byte;
    res_o.ovr      = res_ovr;
    res_o.rdy      = closed_d;
    res_o.len      = closed_d ? LEN_W'(1) + LEN_W'(hsc_d) + LEN_W'(spc_d) + LEN_W'(tsc_d)
                              : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      spc_q    <= '0;
      raw_q    <= '0;
      sum_q    <= '0;
      hsc_q    <= '0;
      tsc_q    <= '0;
      closed_q <= 1'b0;
      slot_q   <= '0;
    end else begin
      state_q  <= state_d;
      spc_q    <= spc_d;
      raw_q    <= raw_d;
      sum_q    <= sum_d;
      hsc_q    <= hsc_d;
      tsc_q    <= tsc_d;
      closed_q <= closed_d;
      slot_q   <= slot_d;
    end
  end

  // Working registers of the current operation.
  always_ff @(posedge clk_i) begin
    pay_q   <= pay_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    chk_q   <= chk_d;
    waddr_q <= waddr_d;
  end

  bsfb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

endmodule

FILE: rtl/byte_stuffed_frame_builder_unit.sv
// Path: a word passes the queue and the output register; an escaped payload byte or a
// read also passes a second sequencer state, and a close passes the slot sequence.
// Throughput: one word a cycle for plain bytes, reads that miss, clears and ignored ops
// while the output is free; escaped bytes, reads and closes hold the single-port store.
// Reset clears the queue, sequencer, counts, sum and closed flag and restores the
// register defaults; the frame store is not cleared and needs no clearing pass.
module byte_stuffed_frame_builder_unit import bsfb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [7:0]           data_byte_i,
  input  logic [IDX_W-1:0]     read_index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic [LEN_W-1:0]     frame_length_o,
  output logic                 overrun_o,
  output logic                 frame_ready_o
);

  cfg_t  cfg_q, cfg_d;
  item_t item;
  logic  item_valid, item_pop;
  logic  res_ok, res_valid;
  res_t  res, res_q;
  logic  out_valid_q, out_valid_d;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_HEAD: cfg_d.head = cfg_data_i;
        REG_ESC:  cfg_d.esc  = cfg_data_i;
        REG_MASK: cfg_d.mask = cfg_data_i;
        default:  cfg_d      = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head <= HEAD_RESET;
      cfg_q.esc  <= ESC_RESET;
      cfg_q.mask <= MASK_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bsfb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .read_index_i(read_index_i),
    .item_o      (item),
    .item_valid_o(item_valid),
    .item_pop_i  (item_pop)
  );

  bsfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .item_valid_i(item_valid),
    .item_pop_o  (item_pop),
    .res_ok_i    (res_ok),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register: the back may finish a word whenever this slot frees.
  assign res_ok = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = res_q.out_byte;
  assign frame_length_o = res_q.len;
  assign overrun_o      = res_q.ovr;
  assign frame_ready_o  = res_q.rdy;

endmodule
